// ===== src/shc_pkg.sv =====
`timescale 1ns / 1ps

package shc_pkg;

   localparam int HASH_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int CHECK_W     = 14;
   localparam int LEN_W       = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [HASH_W-1:0]  HASH_MULT_SHIFT = 32'd5;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
   localparam logic [BYTE_W-1:0]  BYTE_END        = 8'h00;

   // modulo by reciprocal: quotient = (hash * RECIP) >> RECIP_SHIFT
   localparam logic [CHECK_W-1:0] CHECK_MOD   = 14'd9999;
   localparam logic [HASH_W-1:0]  RECIP       = 32'd3518789088;
   localparam int                 RECIP_SHIFT = 45;
   localparam int                 PROD_W      = 2 * HASH_W;
   localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam int                 REM_W       = CHECK_W + 1;

   // register index taken from the word address
   localparam logic REG_MAX_LENGTH = 1'b0;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } term_type;

endpackage

// ===== src/shc_csr.sv =====
`timescale 1ns / 1ps

module shc_csr
   import shc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LEN_W-1:0]      max_length
);

   logic [LEN_W-1:0] max_length_ff;
   logic [LEN_W-1:0] max_length_in;
   logic             reg_index;
   logic             write_en;

   assign reg_index = csr_paddr[CSR_ADDR_W-1];
   assign write_en  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      max_length_in = max_length_ff;
      if (write_en && (reg_index == REG_MAX_LENGTH)) begin
         max_length_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= '0;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_MAX_LENGTH) begin
         csr_prdata = CSR_DATA_W'(max_length_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign max_length = max_length_ff;

endmodule

// ===== src/shc_hash_core.sv =====
`timescale 1ns / 1ps

module shc_hash_core
   import shc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LEN_W-1:0]  max_length,
   input  logic              accept,
   input  logic [BYTE_W-1:0] char_byte,
   output term_type          term
);

   logic [HASH_W-1:0]  hash_ff;
   logic [HASH_W-1:0]  hash_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               is_end;
   logic               room;

   assign is_end = (char_byte == BYTE_END);
   assign room   = (max_length == '0) || (count_ff < max_length);

   always_comb begin
      hash_in  = hash_ff;
      count_in = count_ff;
      if (accept) begin
         if (is_end) begin
            hash_in  = '0;
            count_in = '0;
         end else if (room) begin
            // hash * 31 + byte
            hash_in = (hash_ff << HASH_MULT_SHIFT) - hash_ff + HASH_W'(char_byte);
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
      end
   end

   assign term.valid = accept && is_end;
   assign term.hash  = hash_ff;

endmodule

// ===== src/shc_mod_pipe.sv =====
`timescale 1ns / 1ps

module shc_mod_pipe
   import shc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  term_type           term,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [CHECK_W-1:0] checksum
);

   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   logic               rdy1, rdy2, rdy3, rdyo;
   logic [HASH_W-1:0]  h1_ff, h2_ff, h3_ff;
   logic [QUOT_W-1:0]  q2_ff;
   logic [HASH_W-1:0]  qd3_ff;
   logic [CHECK_W-1:0] sum_ff;
   logic [PROD_W-1:0]  prod;
   logic [HASH_W:0]    qd_full;
   logic [HASH_W-1:0]  diff;
   logic [REM_W-1:0]   rem;
   logic [CHECK_W-1:0] rem_fix;

   assign rdyo = !vo_ff || out_ready;
   assign rdy3 = !v3_ff || rdyo;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in = rdy1 ? term.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign vo_in = rdyo ? v3_ff : vo_ff;

   assign prod    = PROD_W'(h1_ff) * PROD_W'(RECIP);
   assign qd_full = (HASH_W+1)'(q2_ff) * (HASH_W+1)'(CHECK_MOD);
   assign diff    = h3_ff - qd3_ff;
   assign rem     = diff[REM_W-1:0];

   always_comb begin
      rem_fix = rem[CHECK_W-1:0];
      if (rem >= REM_W'(CHECK_MOD)) begin
         rem_fix = CHECK_W'(rem - REM_W'(CHECK_MOD));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         h1_ff <= term.hash;
      end
      if (rdy2) begin
         h2_ff <= h1_ff;
         q2_ff <= prod[PROD_W-1:RECIP_SHIFT];
      end
      if (rdy3) begin
         h3_ff  <= h2_ff;
         qd3_ff <= qd_full[HASH_W-1:0];
      end
      if (rdyo) begin
         sum_ff <= rem_fix;
      end
   end

   assign in_ready  = rdy1;
   assign out_valid = vo_ff;
   assign checksum  = sum_ff;

endmodule

// ===== src/string_hash_checksum_unit.sv =====
`timescale 1ns / 1ps
// string hash checksum unit
// req channel: one string byte per word in req_tdata[7:0]; a zero byte ends the
// string. every nonzero byte updates the hash as hash*31 + byte (mod 2^32)
// unless the byte count has reached a nonzero max_length.
// rsp channel: one word per terminating zero byte, checksum = hash mod 9999 in
// rsp_tdata[13:0]; hash and count then clear for the next string.
// csr port: register max_length at byte address 0, zero means no limit.
// throughput: one byte per cycle while req_tready is high, the hash update is
// a single shift-subtract-add. a checksum reaches rsp through the four-register
// reduction pipeline (snapshot, reciprocal multiply, quotient multiply,
// remainder and correction).
// when rsp_tready is low the pipeline fills up; req_tready drops only once all
// four stages hold a checksum.
// reset clears the hash, the count and max_length, and empties the pipeline.

module string_hash_checksum_unit
   import shc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // char_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // checksum, zero pad
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0]   max_length;
   logic               accept;
   logic               pipe_ready;
   term_type           term;
   logic [CHECK_W-1:0] checksum;

   assign accept     = req_tvalid && pipe_ready;
   assign req_tready = pipe_ready;

   shc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   shc_hash_core u_hash_core (
      .clock      (clock),
      .reset      (reset),
      .max_length (max_length),
      .accept     (accept),
      .char_byte  (req_tdata[BYTE_W-1:0]),
      .term       (term)
   );

   shc_mod_pipe u_mod_pipe (
      .clock     (clock),
      .reset     (reset),
      .term      (term),
      .in_ready  (pipe_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .checksum  (checksum)
   );

   assign rsp_tdata = 16'(checksum);

endmodule

// ===== src/shc_checker.sv =====
`timescale 1ns / 1ps

module shc_checker
   import shc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [15:0]           rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic wr_max;

   assign wr_max = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_MAX_LENGTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:14] == 2'b00) && (rsp_tdata[13:0] < 14'd9999))
      else $error("checksum out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without a blocked rsp word");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      $past(wr_max) && !$past(reset) && (csr_paddr[CSR_ADDR_W-1] == REG_MAX_LENGTH)
      |-> csr_prdata == CSR_DATA_W'($past(csr_pwdata[LEN_W-1:0])))
      else $error("max_length readback mismatch");

endmodule

bind string_hash_checksum_unit shc_checker u_shc_checker (.*);

// ===== tb/string_hash_checksum_unit_tb.sv =====
`timescale 1ns / 1ps

module string_hash_checksum_unit_tb
   import shc_pkg::*;
();

   localparam int                    HALF_PERIOD  = 5;
   localparam int                    RESET_CYCLES = 12;
   localparam int                    DRAIN_CYCLES = 10;
   localparam int                    HOLD_CYCLES  = 300;
   localparam int                    QUIET_LIMIT  = 4000;
   localparam int                    SHOW_LIMIT   = 10;
   localparam logic [HASH_W-1:0]     HASH_FACTOR  = 32'd31;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR   = {REG_MAX_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR   = 3'd4;
   localparam logic [LEN_W-1:0]      NO_LIMIT     = '0;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // char_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;          // checksum, zero pad
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [HASH_W-1:0]  hash_acc     = '0;
   logic [COUNT_W-1:0] char_count   = '0;
   logic [LEN_W-1:0]   length_limit = '0;

   logic [BYTE_W-1:0]  char_queue[$];
   logic [CHECK_W-1:0] checksum_queue[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_trig     = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   bit  req_fire      = 1'b0;
   int  quiet_cycles  = 0;
   int  error_count   = 0;
   int  chars_sent    = 0;
   int  sums_checked  = 0;
   int  limit_writes  = 0;
   int  stall_cycles  = 0;

   string_hash_checksum_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // hash update for one accepted byte, returns 1 with the checksum on a terminator
   function automatic bit hash_char(input logic [BYTE_W-1:0] char_in,
                                    output logic [CHECK_W-1:0] checksum);
      checksum = '0;
      if (char_in == BYTE_END) begin
         checksum   = CHECK_W'(hash_acc % HASH_W'(CHECK_MOD));
         hash_acc   = '0;
         char_count = '0;
         return 1'b1;
      end
      if (length_limit == NO_LIMIT || char_count < length_limit) begin
         hash_acc = hash_acc * HASH_FACTOR + HASH_W'(char_in);
         if (char_count != COUNT_MAX)
            char_count = char_count + COUNT_W'(1);
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= SHOW_LIMIT)
         $display("mismatch %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= char_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver with long hold-off on request
   always @(negedge clock) begin
      if (hold_trig != hold_seen) begin
         hold_seen = hold_trig;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [CHECK_W-1:0] checksum;
      logic [CHECK_W-1:0] want;
      req_fire = !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && !req_tready)
         stall_cycles++;
      if (req_fire) begin
         chars_sent++;
         if (hash_char(req_tdata, checksum))
            checksum_queue.push_back(checksum);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (checksum_queue.size() == 0) begin
            report_mismatch("unexpected checksum word", 32'd0, 32'(rsp_tdata));
         end else begin
            want = checksum_queue.pop_front();
            sums_checked++;
            if (rsp_tdata !== {2'b00, want})
               report_mismatch("checksum", 32'(want), 32'(rsp_tdata));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("string_hash_checksum_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr) begin
         if (addr == LIMIT_ADDR) begin
            length_limit = data[LEN_W-1:0];
            limit_writes++;
         end
      end else if (csr_prdata !== CSR_DATA_W'(length_limit)) begin
         report_mismatch("max_length readback", 32'(length_limit), csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (char_queue.size() != 0 || req_tvalid || checksum_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] random_char();
      case ($urandom_range(9))
         0:       return 8'hFF;
         1:       return 8'h01;
         2:       return 8'h80;
         default: return BYTE_W'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void queue_chars(input int len);
      for (int i = 0; i < len; i++)
         char_queue.push_back(random_char());
   endfunction

   function automatic void queue_strings(input int budget);
      int pushed;
      int len;
      pushed = 0;
      while (pushed < budget) begin
         case ($urandom_range(9))
            0:       len = 0;
            1:       len = $urandom_range(40, 100);
            default: len = $urandom_range(1, 24);
         endcase
         queue_chars(len);
         char_queue.push_back(BYTE_END);
         pushed += len + 1;
      end
   endfunction

   function automatic logic [LEN_W-1:0] pick_limit(input int sel);
      case (sel % 6)
         0:       return NO_LIMIT;
         1:       return 16'd1;
         2:       return LEN_W'($urandom_range(2, 16));
         3:       return LEN_W'($urandom_range(17, 200));
         4:       return 16'hFFFF;
         default: return LEN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, LIMIT_ADDR, '0);
      csr_access(1'b1, LIMIT_ADDR, CSR_DATA_W'(NO_LIMIT));

      // directed: empty strings, byte extremes, short strings
      char_queue = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00,
                     8'h41, 8'h42, 8'h43, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'hFE, 8'h00};
      wait_idle();

      // bytes past the limit are dropped
      csr_access(1'b1, LIMIT_ADDR, 32'd3);
      char_queue = '{8'h10, 8'h20, 8'h30, 8'h40, 8'hFF, 8'h00, 8'h00};
      wait_idle();

      // write to an unmapped register must leave max_length alone
      csr_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF);
      csr_access(1'b0, LIMIT_ADDR, '0);

      // limit lowered mid-string
      csr_access(1'b1, LIMIT_ADDR, CSR_DATA_W'(NO_LIMIT));
      queue_chars(6);
      wait_idle();
      csr_access(1'b1, LIMIT_ADDR, 32'd2);
      queue_chars(3);
      char_queue.push_back(BYTE_END);
      wait_idle();

      // limit raised mid-string
      csr_access(1'b1, LIMIT_ADDR, 32'd4);
      queue_chars(6);
      wait_idle();
      csr_access(1'b1, LIMIT_ADDR, 32'd8);
      queue_chars(3);
      char_queue.push_back(BYTE_END);
      wait_idle();

      // long string without a limit, then the top limit set mid-string
      csr_access(1'b1, LIMIT_ADDR, CSR_DATA_W'(NO_LIMIT));
      queue_chars(120);
      wait_idle();
      csr_access(1'b1, LIMIT_ADDR, 32'hFFFF);
      csr_access(1'b0, LIMIT_ADDR, '0);
      queue_chars(5);
      char_queue.push_back(BYTE_END);
      wait_idle();

      // receiver holds off while the sender keeps pushing terminators
      csr_access(1'b1, LIMIT_ADDR, 32'd5);
      hold_trig++;
      for (int i = 0; i < 40; i++)
         char_queue.push_back(BYTE_END);
      queue_strings(60);
      wait_idle();

      // random strings under three idle mixes and several limits
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 79 : 0;
         recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 10 : 0;
         for (int seg = 0; seg < 6; seg++) begin
            csr_access(1'b1, LIMIT_ADDR, CSR_DATA_W'(pick_limit(seg + mode)));
            queue_strings(60);
            wait_idle();
         end
      end

      $display("covered %0d bytes and %0d checksums over %0d max_length writes",
               chars_sent, sums_checked, limit_writes);
      $display("including empty, capped, mid-string limit and long strings, %0d input stalls",
               stall_cycles);
      if (error_count == 0 && checksum_queue.size() == 0) begin
         $display("string_hash_checksum_unit_tb: clean");
      end else begin
         $display("string_hash_checksum_unit_tb: errors");
      end
      $finish;
   end

endmodule
